@@ src/cths_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cths_pkg
// Shared types and constants for the circle table hit select block.
// ----------------------------------------------------------------------------
package cths_pkg;

   localparam int CAPACITY_DEFAULT   = 128;
   localparam int COORD_BITS_DEFAULT = 10;

   localparam int CMD_BITS    = 2;
   localparam int POINT_BITS  = 10;
   localparam int COLOR_BITS  = 8;
   localparam int RADIUS_BITS = 9;
   localparam int INDEX_BITS  = 7;
   localparam int COUNT_BITS  = 8;

   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 9'd50;

   localparam logic [CMD_BITS-1:0] CMD_SELECT   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_DESELECT = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_MOVE     = 2'd2;

   typedef struct packed {
      logic valid;
      logic last;
   } scan_tag_type;

endpackage

@@ src/cths_hit_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cths_hit_unit
// Three stage point in circle test, one stored circle per cycle.
// ----------------------------------------------------------------------------
module cths_hit_unit
   import cths_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int IDX_BITS   = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  flush,
   input  scan_tag_type          in_tag,
   input  logic [IDX_BITS-1:0]   in_idx,
   input  logic [COORD_BITS-1:0] point_x,
   input  logic [COORD_BITS-1:0] point_y,
   input  logic [COORD_BITS-1:0] center_x,
   input  logic [COORD_BITS-1:0] center_y,
   input  logic [RADIUS_BITS-1:0] radius,
   output scan_tag_type          out_tag,
   output logic [IDX_BITS-1:0]   out_idx,
   output logic                  out_hit
);

   localparam int SQ_BITS  = 2 * COORD_BITS;
   localparam int SUM_BITS = SQ_BITS + 1;
   localparam int R2_BITS  = 2 * RADIUS_BITS;
   localparam int CMP_BITS = (SUM_BITS > R2_BITS) ? SUM_BITS : R2_BITS;

   scan_tag_type          tag1_ff, tag2_ff, tag3_ff;
   logic [IDX_BITS-1:0]   idx1_ff, idx2_ff, idx3_ff;
   logic [COORD_BITS-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [RADIUS_BITS-1:0] r_ff;
   logic [SQ_BITS-1:0]    dx2_ff, dy2_ff;
   logic [R2_BITS-1:0]    r2_ff;
   logic                  hit_ff;
   logic [SUM_BITS-1:0]   sum;
   logic                  hit_in;

   always_comb begin
      dx_in  = (point_x >= center_x) ? point_x - center_x : center_x - point_x;
      dy_in  = (point_y >= center_y) ? point_y - center_y : center_y - point_y;
      sum    = SUM_BITS'(dx2_ff) + SUM_BITS'(dy2_ff);
      hit_in = CMP_BITS'(sum) <= CMP_BITS'(r2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff <= in_idx;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      r_ff    <= radius;
      idx2_ff <= idx1_ff;
      dx2_ff  <= SQ_BITS'(dx_ff) * SQ_BITS'(dx_ff);
      dy2_ff  <= SQ_BITS'(dy_ff) * SQ_BITS'(dy_ff);
      r2_ff   <= R2_BITS'(r_ff) * R2_BITS'(r_ff);
      idx3_ff <= idx2_ff;
      hit_ff  <= hit_in;
   end

   assign out_tag = tag3_ff;
   assign out_idx = idx3_ff;
   assign out_hit = hit_ff;

endmodule

@@ src/circle_table_hit_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_table_hit_select
// Circle table with first-hit selection, append on miss and move of the
// selected circle.
// ----------------------------------------------------------------------------
//  channel  direction  transaction
//  req_     in         command in tuser, point and colour in tdata
//  rsp_     out        selection, added, full flags and stored count
//  csr_     in         radius for newly added circles
//
//  A select posts its response once the scan finds a hit or has tested the
//  last stored circle (no scan with an empty table): the circle memory read
//  and the three stage hit unit scan one circle per cycle, stopping at the
//  first hit. Deselect, move and unused commands post theirs without a scan.
//  No request is taken while a transaction is in progress; a stalled
//  response holds until taken. Reset clears the count and the selection.
// ----------------------------------------------------------------------------
module circle_table_hit_select
   import cths_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEFAULT,
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // point_x[9:0], point_y[19:10], color_red[27:20], color_green[35:28],
   // color_blue[43:36], zero[47:44]
   input  logic [47:0]            req_tdata,
   // command[1:0]
   input  logic [CMD_BITS-1:0]    req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // selection_valid[0], selection_index[7:1], circle_added[8],
   // table_full[9], stored_count[17:10], zero[23:18]
   output logic [23:0]            rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [RADIUS_BITS-1:0] csr_wr_data
);

   localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_FINISH = 3'd3;

   logic [2:0]              state_ff, state_in;
   logic [CMD_BITS-1:0]     cmd_ff, cmd_in;
   logic [COORD_BITS-1:0]   px_ff, px_in, py_ff, py_in;
   logic [3*COLOR_BITS-1:0] color_ff, color_in;
   logic                    hit_ff, hit_in;
   logic [IDX_BITS-1:0]     hit_idx_ff, hit_idx_in;
   logic [IDX_BITS-1:0]     scan_ff, scan_in;
   logic [CNT_BITS-1:0]     total_ff, total_in;
   logic                    sel_flag_ff, sel_flag_in;
   logic [IDX_BITS-1:0]     sel_ff, sel_in;
   logic [RADIUS_BITS-1:0]  radius_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [23:0]             rsp_data_ff, rsp_data_in;

   logic [COORD_BITS-1:0]   cx_mem [CAPACITY];
   logic [COORD_BITS-1:0]   cy_mem [CAPACITY];
   logic [RADIUS_BITS-1:0]  r_mem [CAPACITY];
   logic [3*COLOR_BITS-1:0] color_mem [CAPACITY];

   logic [COORD_BITS-1:0]   rd_x_ff, rd_y_ff;
   logic [RADIUS_BITS-1:0]  rd_r_ff;
   logic [IDX_BITS-1:0]     rd_idx_ff;
   scan_tag_type            rd_tag_ff, rd_tag_in;

   logic                    wr_xy, wr_add;
   logic [IDX_BITS-1:0]     wr_addr;
   logic                    issue, found, flush, rsp_free;
   logic                    added, full;
   scan_tag_type            out_tag;
   logic [IDX_BITS-1:0]     out_idx;
   logic                    out_hit;
   logic [COORD_BITS+POINT_BITS-1:0] px_ext, py_ext;
   logic [CNT_BITS+COUNT_BITS-1:0]   count_ext;
   logic [IDX_BITS+INDEX_BITS-1:0]   index_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign found = out_tag.valid && (out_hit || out_tag.last);
   assign issue = (state_ff == ST_SCAN) && !found;
   assign flush = ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN)) && found;

   always_comb begin
      px_ext = {{COORD_BITS{1'b0}}, req_tdata[9:0]};
      py_ext = {{COORD_BITS{1'b0}}, req_tdata[19:10]};
      rd_tag_in.valid = issue;
      rd_tag_in.last  = (CNT_BITS'(scan_ff) == total_ff - CNT_BITS'(1));
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      color_in     = color_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      scan_in      = scan_ff;
      total_in     = total_ff;
      sel_flag_in  = sel_flag_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_xy        = 1'b0;
      wr_add       = 1'b0;
      wr_addr      = total_ff[IDX_BITS-1:0];
      added        = 1'b0;
      full         = 1'b0;
      count_ext    = '0;
      index_ext    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser;
               px_in    = px_ext[COORD_BITS-1:0];
               py_in    = py_ext[COORD_BITS-1:0];
               color_in = {req_tdata[27:20], req_tdata[35:28], req_tdata[43:36]};
               hit_in   = 1'b0;
               scan_in  = '0;
               if (req_tuser == CMD_SELECT && total_ff != '0) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN, ST_DRAIN: begin
            if (found) begin
               hit_in     = out_hit;
               hit_idx_in = out_idx;
               state_in   = ST_FINISH;
            end else if (issue) begin
               scan_in = scan_ff + IDX_BITS'(1);
               if (rd_tag_in.last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               case (cmd_ff)
                  CMD_SELECT: begin
                     if (hit_ff) begin
                        sel_flag_in = 1'b1;
                        sel_in      = hit_idx_ff;
                     end else if (total_ff < CNT_BITS'(CAPACITY)) begin
                        wr_add   = 1'b1;
                        added    = 1'b1;
                        total_in = total_ff + CNT_BITS'(1);
                     end else begin
                        full = 1'b1;
                     end
                  end
                  CMD_DESELECT: begin
                     sel_flag_in = 1'b0;
                     sel_in      = '0;
                  end
                  CMD_MOVE: begin
                     wr_xy   = sel_flag_ff;
                     wr_addr = sel_ff;
                  end
                  default: begin
                  end
               endcase
               count_ext    = {{COUNT_BITS{1'b0}}, total_in};
               index_ext    = {{INDEX_BITS{1'b0}}, sel_in};
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, count_ext[COUNT_BITS-1:0], full, added,
                               sel_flag_in ? index_ext[INDEX_BITS-1:0] : 7'd0,
                               sel_flag_in};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         sel_flag_ff  <= 1'b0;
         sel_ff       <= '0;
         radius_ff    <= RADIUS_RESET;
         rsp_valid_ff <= 1'b0;
         rd_tag_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         sel_flag_ff  <= sel_flag_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_tag_ff    <= flush ? '0 : rd_tag_in;
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      color_ff    <= color_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      scan_ff     <= scan_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_add || wr_xy) begin
         cx_mem[wr_addr] <= px_ff;
         cy_mem[wr_addr] <= py_ff;
      end
      if (wr_add) begin
         r_mem[wr_addr]     <= radius_ff;
         color_mem[wr_addr] <= color_ff;
      end
      rd_x_ff   <= cx_mem[scan_ff];
      rd_y_ff   <= cy_mem[scan_ff];
      rd_r_ff   <= r_mem[scan_ff];
      rd_idx_ff <= scan_ff;
   end

   cths_hit_unit #(
      .COORD_BITS (COORD_BITS),
      .IDX_BITS   (IDX_BITS)
   ) u_hit (
      .clock    (clock),
      .reset    (reset),
      .flush    (flush),
      .in_tag   (rd_tag_ff),
      .in_idx   (rd_idx_ff),
      .point_x  (px_ff),
      .point_y  (py_ff),
      .center_x (rd_x_ff),
      .center_y (rd_y_ff),
      .radius   (rd_r_ff),
      .out_tag  (out_tag),
      .out_idx  (out_idx),
      .out_hit  (out_hit)
   );

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!rd_tag_ff.valid && !out_tag.valid))
      else $error("scan pipeline not empty while idle");

   a_total_cap: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_BITS'(CAPACITY))
      else $error("stored count beyond capacity");

   a_sel_stored: assert property (@(posedge clock) disable iff (reset)
      sel_flag_ff |-> (CNT_BITS'(sel_ff) < total_ff))
      else $error("selection points past stored circles");

   a_rsp_on_finish: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && rsp_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finish did not post a response");

endmodule
